>>> rtl/core/mam_pkg.sv
// Package for the matrix add and multiply unit.
// Shared widths, result kind codes, register indexes and control structs.
// No dependencies.
package mam_pkg;

    localparam int VALUE_W   = 34;  // width of a sum or dot product result
    localparam int IDX_W     = 2;   // row and column index width
    localparam int DIM_W     = 3;   // dimension register width
    localparam int CFG_IDX_W = 2;   // configuration register index width

    // result kinds
    localparam logic [1:0] KIND_SUM  = 2'd0;
    localparam logic [1:0] KIND_PROD = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_A_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B_COLS = 2'd3;

    // one term handed to the multiply-accumulate unit
    typedef struct packed {
        logic valid;
        logic first;      // start a new accumulation
        logic last_term;  // final term of this result
        logic add;        // a + b instead of a * b
    } t_mac_ctl;

    // one result handed from the sequencer to the output register
    typedef struct packed {
        logic             valid;
        logic [1:0]       kind;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
    } t_emit;

    // true when idx is the last position of a dimension of size dim
    function automatic logic is_end(input logic [IDX_W-1:0] idx,
                                    input logic [DIM_W-1:0] dim);
        return DIM_W'(idx) == (dim - DIM_W'(1));
    endfunction

endpackage

>>> rtl/core/matrix_add_and_multiply_unit.sv
// Top level of the integer matrix add and multiply unit.
// Holds the A and B element memories and the output register.
// Depends on mam_pkg, mam_seq and mam_mac.

// Elements of A (a_rows x a_cols) and then B (b_rows x b_cols) arrive
// row-major, one transaction each, and are taken one per cycle. Accepting the
// final element of B starts a run and holds o_stall high until it ends: first
// every element of A+B (kind 0) if both matrices have the same shape, then
// every element of A*B (kind 1) if a_cols equals b_rows, each in row-major
// order; if neither applies a single kind 2 transaction with zero index and
// value goes out. o_last marks the final result of the run. All arithmetic is
// done by one shared multiply-accumulate unit: a sum result has one term and a
// product result a_cols terms, issued one per cycle; the read, multiply and
// accumulate stages drain and the result is emitted once the output register
// is free, which i_stall can delay. Values wrap at 34 bits.
// Dimension writes take effect at once, 0 reads as 1 and values above
// MAX_DIM as MAX_DIM; any write restarts loading from the first element of A.
// Configure only while the unit is loading, never during a run.
module matrix_add_and_multiply_unit #(
    parameter int MAX_DIM   = 4,
    parameter int ELEM_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_wr_en,
    input  logic [mam_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mam_pkg::DIM_W-1:0]          i_cfg_data,
    // element input channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [ELEM_BITS-1:0]        i_element,
    // result output channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [1:0]                         o_kind,
    output logic [mam_pkg::IDX_W-1:0]          o_row_index,
    output logic [mam_pkg::IDX_W-1:0]          o_col_index,
    output logic signed [mam_pkg::VALUE_W-1:0] o_value,
    output logic                               o_last
);

    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic signed [ELEM_BITS-1:0] r_store_a [STORE_DEPTH];
    logic signed [ELEM_BITS-1:0] r_store_b [STORE_DEPTH];
    logic signed [ELEM_BITS-1:0] r_rd_a;
    logic signed [ELEM_BITS-1:0] r_rd_b;
    mam_pkg::t_mac_ctl           r_rd_ctl;

    logic                               we_a, we_b;
    logic [ADDR_W-1:0]                  waddr, raddr_a, raddr_b;
    mam_pkg::t_mac_ctl                  issue;
    mam_pkg::t_emit                     emit;
    logic signed [mam_pkg::VALUE_W-1:0] mac_acc;
    logic                               mac_done;
    logic                               out_free;

    logic                               r_o_valid;
    logic [1:0]                         r_o_kind;
    logic [mam_pkg::IDX_W-1:0]          r_o_row;
    logic [mam_pkg::IDX_W-1:0]          r_o_col;
    logic signed [mam_pkg::VALUE_W-1:0] r_o_value;
    logic                               r_o_last;

    // output register can take a new result when empty or being drained
    assign out_free = !r_o_valid || !i_stall;

    mam_seq #(
        .MAX_DIM (MAX_DIM),
        .ADDR_W  (ADDR_W)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_valid),
        .i_mac_done  (mac_done),
        .i_out_free  (out_free),
        .o_stall     (o_stall),
        .o_we_a      (we_a),
        .o_we_b      (we_b),
        .o_waddr     (waddr),
        .o_raddr_a   (raddr_a),
        .o_raddr_b   (raddr_b),
        .o_issue     (issue),
        .o_emit      (emit)
    );

    // element memories: one write and one registered read each per cycle
    always_ff @(posedge i_clk) begin
        if (we_a) begin
            r_store_a[waddr] <= i_element;
        end
        if (we_b) begin
            r_store_b[waddr] <= i_element;
        end
        r_rd_a <= r_store_a[raddr_a];
        r_rd_b <= r_store_b[raddr_b];
    end

    // term control travels alongside the memory read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ctl <= '0;
        end else begin
            r_rd_ctl <= issue;
        end
    end

    mam_mac #(
        .ELEM_BITS (ELEM_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_a     (r_rd_a),
        .i_b     (r_rd_b),
        .i_ctl   (r_rd_ctl),
        .o_acc   (mac_acc),
        .o_done  (mac_done)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (emit.valid) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
        if (emit.valid) begin
            r_o_kind  <= emit.kind;
            r_o_row   <= emit.row;
            r_o_col   <= emit.col;
            r_o_last  <= emit.last;
            r_o_value <= (emit.kind == mam_pkg::KIND_ERR) ? '0 : mac_acc;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_kind      = r_o_kind;
    assign o_row_index = r_o_row;
    assign o_col_index = r_o_col;
    assign o_value     = r_o_value;
    assign o_last      = r_o_last;

endmodule

>>> rtl/core/mam_mac.sv
// Shared multiply-accumulate unit: registered multiply (or add), then accumulate.
// Depends on mam_pkg.
module mam_mac #(
    parameter int ELEM_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic signed [ELEM_BITS-1:0]        i_a,
    input  logic signed [ELEM_BITS-1:0]        i_b,
    input  mam_pkg::t_mac_ctl                  i_ctl,
    output logic signed [mam_pkg::VALUE_W-1:0] o_acc,
    output logic                               o_done
);

    logic signed [2*ELEM_BITS-1:0]      prod_full;
    logic signed [mam_pkg::VALUE_W-1:0] a_ext;
    logic signed [mam_pkg::VALUE_W-1:0] b_ext;
    logic signed [mam_pkg::VALUE_W-1:0] r_term;
    logic signed [mam_pkg::VALUE_W-1:0] r_acc;
    mam_pkg::t_mac_ctl                  r_ctl;
    logic                               r_done;

    assign prod_full = i_a * i_b;
    assign a_ext     = mam_pkg::VALUE_W'(i_a);
    assign b_ext     = mam_pkg::VALUE_W'(i_b);

    // stage 1: product or sum, wrapped to the result width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        if (i_ctl.valid) begin
            r_term <= i_ctl.add ? (a_ext + b_ext) : mam_pkg::VALUE_W'(prod_full);
        end
    end

    // stage 2: accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_ctl.valid && r_ctl.last_term;
        end
        if (r_ctl.valid) begin
            r_acc <= r_ctl.first ? r_term : (r_acc + r_term);
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

>>> rtl/core/mam_seq.sv
// Sequencer: dimension registers, load counters and result/term iteration.
// Depends on mam_pkg.
module mam_seq #(
    parameter int MAX_DIM = 4,
    parameter int ADDR_W  = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [mam_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mam_pkg::DIM_W-1:0]       i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_mac_done,
    input  logic                            i_out_free,
    output logic                            o_stall,
    output logic                            o_we_a,
    output logic                            o_we_b,
    output logic [ADDR_W-1:0]               o_waddr,
    output logic [ADDR_W-1:0]               o_raddr_a,
    output logic [ADDR_W-1:0]               o_raddr_b,
    output mam_pkg::t_mac_ctl               o_issue,
    output mam_pkg::t_emit                  o_emit
);

    localparam logic [1:0] S_LOAD  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    localparam int DW = mam_pkg::DIM_W;
    localparam int IW = mam_pkg::IDX_W;

    logic [1:0]    r_state, n_state;
    logic [DW-1:0] r_a_rows, r_a_cols, r_b_rows, r_b_cols;
    logic [IW-1:0] r_row, n_row;
    logic [IW-1:0] r_col, n_col;
    logic [IW-1:0] r_k, n_k;
    logic          r_phase_b, n_phase_b;
    logic          r_mode_add, n_mode_add;
    logic          r_mul_ok, n_mul_ok;
    logic          r_err, n_err;

    logic [DW-1:0] ar, ac, br, bc;
    logic [DW-1:0] res_cols;
    logic          accept;
    logic          add_ok, mul_ok;

    function automatic logic [DW-1:0] dim_of(input logic [DW-1:0] v);
        if (v == '0) begin
            return DW'(1);
        end else if (v > DW'(MAX_DIM)) begin
            return DW'(MAX_DIM);
        end
        return v;
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [IW-1:0] r,
                                                  input logic [IW-1:0] c);
        return ADDR_W'(r * MAX_DIM + c);
    endfunction

    assign ar = dim_of(r_a_rows);
    assign ac = dim_of(r_a_cols);
    assign br = dim_of(r_b_rows);
    assign bc = dim_of(r_b_cols);

    assign add_ok   = (ar == br) && (ac == bc);
    assign mul_ok   = (ac == br);
    assign res_cols = r_mode_add ? ac : bc;
    assign accept   = i_in_valid && (r_state == S_LOAD);
    assign o_stall  = (r_state != S_LOAD);

    assign o_waddr   = addr_of(r_row, r_col);
    assign o_we_a    = accept && !r_phase_b;
    assign o_we_b    = accept && r_phase_b;
    assign o_raddr_a = r_mode_add ? addr_of(r_row, r_col) : addr_of(r_row, r_k);
    assign o_raddr_b = r_mode_add ? addr_of(r_row, r_col) : addr_of(r_k, r_col);

    always_comb begin
        n_state    = r_state;
        n_row      = r_row;
        n_col      = r_col;
        n_k        = r_k;
        n_phase_b  = r_phase_b;
        n_mode_add = r_mode_add;
        n_mul_ok   = r_mul_ok;
        n_err      = r_err;
        o_issue    = '0;
        o_emit     = '0;

        unique case (r_state)
            S_LOAD: begin
                if (accept) begin
                    if (!mam_pkg::is_end(r_col, r_phase_b ? bc : ac)) begin
                        n_col = r_col + 1'b1;
                    end else if (!mam_pkg::is_end(r_row, r_phase_b ? br : ar)) begin
                        n_col = '0;
                        n_row = r_row + 1'b1;
                    end else begin
                        n_col = '0;
                        n_row = '0;
                        if (!r_phase_b) begin
                            n_phase_b = 1'b1;
                        end else begin
                            // last element of B: start the run
                            n_phase_b  = 1'b0;
                            n_mode_add = add_ok;
                            n_mul_ok   = mul_ok;
                            n_err      = !add_ok && !mul_ok;
                            n_k        = '0;
                            n_state    = (!add_ok && !mul_ok) ? S_EMIT : S_ISSUE;
                        end
                    end
                end
                if (i_cfg_wr_en) begin
                    n_row     = '0;
                    n_col     = '0;
                    n_phase_b = 1'b0;
                end
            end
            S_ISSUE: begin
                o_issue.valid     = 1'b1;
                o_issue.add       = r_mode_add;
                o_issue.first     = r_mode_add || (r_k == '0);
                o_issue.last_term = r_mode_add || mam_pkg::is_end(r_k, ac);
                if (o_issue.last_term) begin
                    n_k     = '0;
                    n_state = S_WAIT;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_WAIT: begin
                if (i_mac_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_out_free) begin
                    o_emit.valid = 1'b1;
                    o_emit.row   = r_row;
                    o_emit.col   = r_col;
                    o_emit.kind  = r_err      ? mam_pkg::KIND_ERR :
                                   r_mode_add ? mam_pkg::KIND_SUM : mam_pkg::KIND_PROD;
                    if (r_err) begin
                        o_emit.last = 1'b1;
                        n_err       = 1'b0;
                        n_state     = S_LOAD;
                    end else if (!mam_pkg::is_end(r_col, res_cols)) begin
                        n_col   = r_col + 1'b1;
                        n_state = S_ISSUE;
                    end else if (!mam_pkg::is_end(r_row, ar)) begin
                        n_col   = '0;
                        n_row   = r_row + 1'b1;
                        n_state = S_ISSUE;
                    end else begin
                        n_col = '0;
                        n_row = '0;
                        if (r_mode_add && r_mul_ok) begin
                            n_mode_add = 1'b0;
                            n_state    = S_ISSUE;
                        end else begin
                            o_emit.last = 1'b1;
                            n_state     = S_LOAD;
                        end
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_a_rows   <= DW'(4);
            r_a_cols   <= DW'(4);
            r_b_rows   <= DW'(4);
            r_b_cols   <= DW'(4);
            r_row      <= '0;
            r_col      <= '0;
            r_k        <= '0;
            r_phase_b  <= 1'b0;
            r_mode_add <= 1'b0;
            r_mul_ok   <= 1'b0;
            r_err      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_row      <= n_row;
            r_col      <= n_col;
            r_k        <= n_k;
            r_phase_b  <= n_phase_b;
            r_mode_add <= n_mode_add;
            r_mul_ok   <= n_mul_ok;
            r_err      <= n_err;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    mam_pkg::CFG_A_ROWS: r_a_rows <= i_cfg_data;
                    mam_pkg::CFG_A_COLS: r_a_cols <= i_cfg_data;
                    mam_pkg::CFG_B_ROWS: r_b_rows <= i_cfg_data;
                    mam_pkg::CFG_B_COLS: r_b_cols <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> bench/mam_checker.sv
`timescale 1ns / 1ps
// Checker for the matrix add and multiply unit: watches the config port and both channels,
// predicts every result transaction and compares it field by field.
// Depends on mam_pkg.
module mam_checker #(
    parameter int MAX_DIM   = 4,
    parameter int ELEM_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [mam_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mam_pkg::DIM_W-1:0]           i_cfg_data,
    input  logic                                i_elem_valid,
    input  logic                                i_elem_stall,
    input  logic signed [ELEM_BITS-1:0]         i_element,
    input  logic                                i_res_valid,
    input  logic                                i_res_stall,
    input  logic [1:0]                          i_kind,
    input  logic [mam_pkg::IDX_W-1:0]           i_row_index,
    input  logic [mam_pkg::IDX_W-1:0]           i_col_index,
    input  logic signed [mam_pkg::VALUE_W-1:0]  i_value,
    input  logic                                i_last,
    output int                                  o_fail_count,
    output int                                  o_outstanding
);

    localparam int DIM_W   = mam_pkg::DIM_W;
    localparam int IDX_W   = mam_pkg::IDX_W;
    localparam int VALUE_W = mam_pkg::VALUE_W;

    typedef struct packed {
        logic [1:0]         kind;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_matrix_result;

    t_matrix_result due_results[$];
    t_matrix_result got;
    t_matrix_result want;

    logic [DIM_W-1:0]            rows_a, cols_a, rows_b, cols_b;
    logic signed [ELEM_BITS-1:0] mat_a [MAX_DIM*MAX_DIM];
    logic signed [ELEM_BITS-1:0] mat_b [MAX_DIM*MAX_DIM];
    int                          elems_loaded;
    int                          err_cnt = 0;

    // 0 acts as 1, anything above MAX_DIM as MAX_DIM
    function automatic int dim_used(input logic [DIM_W-1:0] raw);
        if (raw == 0) return 1;
        if (int'(raw) > MAX_DIM) return MAX_DIM;
        return int'(raw);
    endfunction

    function automatic void queue_result(input logic [1:0] kind, input int r, input int c,
                                         input longint v, input bit fin);
        t_matrix_result e;
        e.kind  = kind;
        e.row   = IDX_W'(r);
        e.col   = IDX_W'(c);
        e.value = VALUE_W'(v);
        e.last  = fin;
        due_results.push_back(e);
    endfunction

    function automatic void check_field(input string name, input longint exp_v,
                                        input longint act_v);
        if (exp_v != act_v) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
        end
    endfunction

    // stores one element; the element that completes B yields the whole result set
    task automatic absorb_element(input logic signed [ELEM_BITS-1:0] elem);
        int     ar, ac, br, bc, na, nb, pos, total, n, r, c, k;
        longint acc;
        bit     add_ok, mul_ok;
        ar = dim_used(rows_a);
        ac = dim_used(cols_a);
        br = dim_used(rows_b);
        bc = dim_used(cols_b);
        na = ar * ac;
        nb = br * bc;
        if (elems_loaded >= na + nb) elems_loaded = 0;
        if (elems_loaded < na) begin
            mat_a[(elems_loaded / ac) * MAX_DIM + elems_loaded % ac] = elem;
        end else begin
            pos = elems_loaded - na;
            mat_b[(pos / bc) * MAX_DIM + pos % bc] = elem;
        end
        elems_loaded++;
        if (elems_loaded < na + nb) return;
        elems_loaded = 0;

        add_ok = (ar == br) && (ac == bc);
        mul_ok = (ac == br);
        total  = (add_ok ? ar * ac : 0) + (mul_ok ? ar * bc : 0);
        n      = 0;
        if (add_ok) begin
            for (r = 0; r < ar; r++) begin
                for (c = 0; c < ac; c++) begin
                    acc = longint'(mat_a[r * MAX_DIM + c]) + longint'(mat_b[r * MAX_DIM + c]);
                    n++;
                    queue_result(mam_pkg::KIND_SUM, r, c, acc, n == total);
                end
            end
        end
        if (mul_ok) begin
            for (r = 0; r < ar; r++) begin
                for (c = 0; c < bc; c++) begin
                    acc = 0;
                    for (k = 0; k < ac; k++)
                        acc += longint'(mat_a[r * MAX_DIM + k]) *
                               longint'(mat_b[k * MAX_DIM + c]);
                    n++;
                    queue_result(mam_pkg::KIND_PROD, r, c, acc, n == total);
                end
            end
        end
        if (total == 0) queue_result(mam_pkg::KIND_ERR, 0, 0, 0, 1'b1);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rows_a       = 3'd4;
            cols_a       = 3'd4;
            rows_b       = 3'd4;
            cols_b       = 3'd4;
            elems_loaded = 0;
            due_results.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                got = '{i_kind, i_row_index, i_col_index, i_value, i_last};
                if (due_results.size() == 0) begin
                    err_cnt++;
                    $display("%0t: result with nothing expected: kind %0d row %0d col %0d",
                             $time, i_kind, i_row_index, i_col_index);
                    $display("%0t:   value %0d last %0d", $time, i_value, i_last);
                end else begin
                    want = due_results.pop_front();
                    check_field("kind", want.kind, got.kind);
                    check_field("row_index", want.row, got.row);
                    check_field("col_index", want.col, got.col);
                    check_field("value", longint'($signed(want.value)),
                                longint'($signed(got.value)));
                    check_field("last", want.last, got.last);
                end
            end
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    mam_pkg::CFG_A_ROWS: rows_a = i_cfg_data;
                    mam_pkg::CFG_A_COLS: cols_a = i_cfg_data;
                    mam_pkg::CFG_B_ROWS: rows_b = i_cfg_data;
                    mam_pkg::CFG_B_COLS: cols_b = i_cfg_data;
                    default: ;
                endcase
                elems_loaded = 0;
            end
            if (i_elem_valid && !i_elem_stall) absorb_element(i_element);
        end
        o_outstanding <= due_results.size();
        o_fail_count  <= err_cnt;
    end

endmodule

>>> bench/matrix_add_and_multiply_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the matrix add and multiply unit: clock, reset, dimension writes,
// element stimulus, output stall and the verdict. Depends on mam_pkg and mam_checker.
module matrix_add_and_multiply_unit_tb;

    localparam int CFG_IDX_W   = mam_pkg::CFG_IDX_W;
    localparam int DIM_W       = mam_pkg::DIM_W;
    localparam int IDX_W       = mam_pkg::IDX_W;
    localparam int VALUE_W     = mam_pkg::VALUE_W;
    localparam int MAX_DIM     = 4;
    localparam int ELEM_BITS   = 16;
    localparam int RANDOM_END  = 520;   // stop the random part near this many elements
    localparam int CALM_FROM   = 440;   // no idling on either side after this many
    localparam int SETTLE_CYC  = 8;     // quiet time before a register write
    localparam int DRAIN_CYC   = 20;    // quiet time at the very end
    localparam int QUIET_LIMIT = 2000;  // cycles without any transaction before giving up

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [DIM_W-1:0]            i_cfg_data  = '0;
    logic                        i_valid     = 1'b0;
    logic signed [ELEM_BITS-1:0] i_element   = '0;
    logic                        i_stall     = 1'b0;
    logic                        o_stall;
    logic                        o_valid;
    logic [1:0]                  o_kind;
    logic [IDX_W-1:0]            o_row_index;
    logic [IDX_W-1:0]            o_col_index;
    logic signed [VALUE_W-1:0]   o_value;
    logic                        o_last;

    int fail_count;
    int outstanding;
    int items_sent  = 0;
    int quiet_cycles = 0;
    int stall_hold  = 0;
    bit idle_on     = 1'b1;

    // dimension registers as last written, used to size each run
    logic [DIM_W-1:0] cur_ar = 3'd4, cur_ac = 3'd4, cur_br = 3'd4, cur_bc = 3'd4;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    matrix_add_and_multiply_unit #(
        .MAX_DIM   (MAX_DIM),
        .ELEM_BITS (ELEM_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_element   (i_element),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_kind      (o_kind),
        .o_row_index (o_row_index),
        .o_col_index (o_col_index),
        .o_value     (o_value),
        .o_last      (o_last)
    );

    mam_checker #(
        .MAX_DIM   (MAX_DIM),
        .ELEM_BITS (ELEM_BITS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_elem_valid  (i_valid),
        .i_elem_stall  (o_stall),
        .i_element     (i_element),
        .i_res_valid   (o_valid),
        .i_res_stall   (i_stall),
        .i_kind        (o_kind),
        .i_row_index   (o_row_index),
        .i_col_index   (o_col_index),
        .i_value       (o_value),
        .i_last        (o_last),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // Output-side back-pressure: stall bursts of random length separated by random
    // open stretches; held low for good once idling is switched off.
    always @(posedge i_clk) begin
        if (!i_rst_n || !idle_on) begin
            i_stall    <= 1'b0;
            stall_hold <= 0;
        end else if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
        end else if (i_stall) begin
            i_stall    <= 1'b0;
            stall_hold <= $urandom_range(0, 24);
        end else if ($urandom_range(0, 3) == 0) begin
            i_stall    <= 1'b1;
            stall_hold <= $urandom_range(0, 16);
        end
    end

    // Watchdog: any transaction on either channel or a register write restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results still due",
                     $time, QUIET_LIMIT, outstanding);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int dim_used(input logic [DIM_W-1:0] raw);
        if (raw == 0) return 1;
        if (int'(raw) > MAX_DIM) return MAX_DIM;
        return int'(raw);
    endfunction

    // elements in one full run: all of A, then all of B
    function automatic int run_length();
        return dim_used(cur_ar) * dim_used(cur_ac) + dim_used(cur_br) * dim_used(cur_bc);
    endfunction

    // mostly full-range values, with the extremes and small values mixed in
    function automatic logic signed [ELEM_BITS-1:0] random_element();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return ELEM_BITS'($urandom_range(0, 6) - 3);
            default: return ELEM_BITS'($urandom);
        endcase
    endfunction

    // One element transaction. Valid stays high into the next call unless a gap is
    // taken, so back-to-back transactions never toggle it within a step.
    task automatic send_element(input logic signed [ELEM_BITS-1:0] elem);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_element <= elem;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // Stop sending and wait until every predicted result has come out,
    // then wait out the SETTLE_CYC quiet time so the unit can go quiet.
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Writes all four dimension registers back to back; any write also throws
    // away a partly loaded A/B pair.
    task automatic set_dims(input logic [DIM_W-1:0] ar, input logic [DIM_W-1:0] ac,
                            input logic [DIM_W-1:0] br, input logic [DIM_W-1:0] bc);
        settle();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= mam_pkg::CFG_A_ROWS;
        i_cfg_data  <= ar;
        @(posedge i_clk);
        i_cfg_index <= mam_pkg::CFG_A_COLS;
        i_cfg_data  <= ac;
        @(posedge i_clk);
        i_cfg_index <= mam_pkg::CFG_B_ROWS;
        i_cfg_data  <= br;
        @(posedge i_clk);
        i_cfg_index <= mam_pkg::CFG_B_COLS;
        i_cfg_data  <= bc;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_ar = ar;
        cur_ac = ac;
        cur_br = br;
        cur_bc = bc;
    endtask

    initial begin
        int               phase;
        int               runs;
        int               len;
        int               choice;
        logic [DIM_W-1:0] ar, ac, br, bc;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part ----
        // 1x1 and 1x1: both sum and product; most negative squared
        set_dims(3'd1, 3'd1, 3'd1, 3'd1);
        send_element(16'sh8000);
        send_element(16'sh8000);
        send_element(16'sh7FFF);
        send_element(16'sh8000);

        // 1x2 and 1x2: sum only, sums at the positive edge
        set_dims(3'd1, 3'd2, 3'd1, 3'd2);
        send_element(16'sh7FFF);
        send_element(16'sh7FFF);
        send_element(16'sh7FFF);
        send_element(16'sh0001);

        // 1x2 times 2x1: product only, large negative dot product
        set_dims(3'd1, 3'd2, 3'd2, 3'd1);
        send_element(16'sh8000);
        send_element(16'sh7FFF);
        send_element(16'sh7FFF);
        send_element(16'sh8000);

        // 1x1 against 2x1: neither operation fits, single error transaction
        set_dims(3'd1, 3'd1, 3'd2, 3'd1);
        send_element(16'sh1234);
        send_element(16'shFFFF);
        send_element(16'sh0005);

        // Out-of-range registers: 0 -> 1 and 7, 5 -> 4, i.e. 1x4 times 4x1.
        // All most-negative elements give the largest possible dot product.
        set_dims(3'd0, 3'd7, 3'd5, 3'd0);
        repeat (8) send_element(16'sh8000);

        // Partly loaded 2x2 pair, abandoned by the register writes that follow
        set_dims(3'd2, 3'd2, 3'd2, 3'd2);
        repeat (3) send_element(16'sh7FFF);

        // ---- random part ----
        phase = 0;
        while (items_sent < RANDOM_END) begin
            if (items_sent > CALM_FROM) idle_on = 1'b0;

            choice = $urandom_range(0, 9);
            ar     = DIM_W'($urandom_range(1, 4));
            ac     = DIM_W'($urandom_range(1, 4));
            br     = DIM_W'($urandom_range(1, 4));
            bc     = DIM_W'($urandom_range(1, 4));
            if (phase == 0) begin
                // largest shapes once for sure
                ar = 3'd4; ac = 3'd4; br = 3'd4; bc = 3'd4;
            end else if (choice <= 3) begin
                br = ac;                        // product defined
            end else if (choice <= 6) begin
                br = ar;                        // sum defined
                bc = ac;
            end else if (choice == 7) begin
                ac = ar; br = ar; bc = ar;      // square, both defined
            end else begin
                // raw register values, out-of-range codes included
                ar = DIM_W'($urandom_range(0, 7));
                ac = DIM_W'($urandom_range(0, 7));
                br = DIM_W'($urandom_range(0, 7));
                bc = DIM_W'($urandom_range(0, 7));
            end
            set_dims(ar, ac, br, bc);

            len  = run_length();
            runs = $urandom_range(1, 3);
            repeat (runs) begin
                repeat (len) send_element(random_element());
                // now and then hold off until the whole result set is out
                if ($urandom_range(0, 5) == 0) settle();
            end

            // broken sequence: a partial load that the next write discards
            if (len > 1 && $urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, len - 1)) send_element(random_element());

            phase++;
        end

        settle();
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (fail_count == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
